FILE: hw/rtl/bpdc_pkg.sv
// ----------------------------------------------------------------------------
// Button packet drive control: shared types and constants
// Byte codes of the control pad packet, configuration indexes and the
// structs that pass between the parser, the drive logic and the top level.
// ----------------------------------------------------------------------------
package bpdc_pkg;

    // Packet framing bytes
    localparam logic [7:0] START_BYTE = 8'h21;  // '!'
    localparam logic [7:0] KIND_BYTE  = 8'h42;  // 'B'

    // Button numbers
    localparam logic [7:0] BTN_HORN  = 8'h31;   // '1'
    localparam logic [7:0] BTN_BEAM  = 8'h32;   // '2'
    localparam logic [7:0] BTN_BRAKE = 8'h33;   // '3'
    localparam logic [7:0] BTN_UP    = 8'h35;   // '5'
    localparam logic [7:0] BTN_DOWN  = 8'h36;   // '6'
    localparam logic [7:0] BTN_LEFT  = 8'h37;   // '7'
    localparam logic [7:0] BTN_RIGHT = 8'h38;   // '8'

    // Hit byte meaning "pressed"
    localparam logic [7:0] HIT_PRESSED = 8'h31; // '1'

    // Turn request codes
    localparam logic [1:0] TURN_NONE  = 2'd0;
    localparam logic [1:0] TURN_LEFT  = 2'd1;
    localparam logic [1:0] TURN_RIGHT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_SPEED  = 2'd0;
    localparam logic [1:0] CFG_ACCEL_STEP = 2'd1;
    localparam logic [1:0] CFG_BRAKE_STEP = 2'd2;

    // Configuration reset values
    localparam logic [6:0] MAX_SPEED_RST  = 7'd100;
    localparam logic [6:0] ACCEL_STEP_RST = 7'd10;
    localparam logic [6:0] BRAKE_STEP_RST = 7'd10;

    // Configuration seen by the drive logic
    typedef struct packed {
        logic [6:0] max_speed;
        logic [6:0] accel_step;
        logic [6:0] brake_step;
    } cfg_t;

    // Decoded packet for the current byte
    typedef struct packed {
        logic       good;      // packet complete, checksum matches
        logic       bad;       // packet complete, checksum wrong
        logic [7:0] number;    // button number
        logic       pressed;   // hit byte was the pressed code
    } cmd_t;

    // Car status after the current byte
    typedef struct packed {
        logic signed [7:0] right_wheel;
        logic signed [7:0] left_wheel;
        logic              forward;
        logic              beam;
        logic              horn;
        logic              left_sig;
        logic              right_sig;
        logic [1:0]        turn;
    } status_t;

endpackage

FILE: hw/rtl/bpdc_parser.sv
// ----------------------------------------------------------------------------
// Button packet parser
// Frames '!' 'B' number hit checksum and checks the inverted 8-bit sum.
// Phase and captured bytes advance only when the top level takes a byte.
// ----------------------------------------------------------------------------
module bpdc_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic [7:0]      rx_data,
    output bpdc_pkg::cmd_t  cmd
);

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_BANG = 3'd1;
    localparam logic [2:0] PH_NUM  = 3'd2;
    localparam logic [2:0] PH_HIT  = 3'd3;
    localparam logic [2:0] PH_SUM  = 3'd4;

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [7:0] number_reg;
    logic [7:0] number_next;
    logic [7:0] hit_reg;
    logic [7:0] hit_next;
    logic [7:0] sum_expected;

    // Work out the expected checksum byte
    assign sum_expected = ~(bpdc_pkg::START_BYTE + bpdc_pkg::KIND_BYTE + number_reg + hit_reg);

    // Step the framing state
    always_comb
    begin
        phase_next  = phase_reg;
        number_next = number_reg;
        hit_next    = hit_reg;
        unique case (phase_reg)
            PH_BANG:
            begin
                phase_next = (rx_data == bpdc_pkg::KIND_BYTE) ? PH_NUM : PH_HUNT;
            end
            PH_NUM:
            begin
                number_next = rx_data;
                phase_next  = PH_HIT;
            end
            PH_HIT:
            begin
                hit_next   = rx_data;
                phase_next = PH_SUM;
            end
            PH_SUM:
            begin
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = (rx_data == bpdc_pkg::START_BYTE) ? PH_BANG : PH_HUNT;
            end
        endcase
    end

    // Decode the packet closed by this byte
    always_comb
    begin
        cmd.good    = (phase_reg == PH_SUM) && (rx_data == sum_expected);
        cmd.bad     = (phase_reg == PH_SUM) && (rx_data != sum_expected);
        cmd.number  = number_reg;
        cmd.pressed = (hit_reg == bpdc_pkg::HIT_PRESSED);
    end

    // Hold the parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            number_reg <= 8'd0;
            hit_reg    <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            number_reg <= number_next;
            hit_reg    <= hit_next;
        end
    end

    // A completed packet is either good or bad, never both
    a_good_bad_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.good && cmd.bad))
        else $error("parser flags good and bad checksum together");

    // The byte after a checksum byte is always back in the hunt
    a_sum_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_SUM) |=> phase_reg == PH_HUNT)
        else $error("parser did not return to hunting after checksum");

    // Number and hit capture only move while framing a packet
    a_capture_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (number_reg != $past(number_reg)) |-> ($past(phase_reg) == PH_NUM))
        else $error("button number changed outside its phase");

endmodule

FILE: hw/rtl/bpdc_drive.sv
// ----------------------------------------------------------------------------
// Drive state update
// Applies a good packet to wheel speeds, gear, beams and indicators, and
// presents the status after the current byte for the result register.
// ----------------------------------------------------------------------------
module bpdc_drive (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  bpdc_pkg::cfg_t    cfg,
    input  bpdc_pkg::cmd_t    cmd,
    output bpdc_pkg::status_t status
);

    logic signed [7:0] right_level_reg;
    logic signed [7:0] right_level_next;
    logic signed [7:0] left_level_reg;
    logic signed [7:0] left_level_next;
    logic              gear_forward_reg;
    logic              gear_forward_next;
    logic              beam_reg;
    logic              beam_next;
    logic              left_ind_reg;
    logic              left_ind_next;
    logic              right_ind_reg;
    logic              right_ind_next;
    logic              horn;
    logic [1:0]        turn;

    // Step a speed up, stopping at the limit
    function automatic logic signed [7:0] step_up(input logic signed [7:0] v,
                                                   input logic [6:0] m,
                                                   input logic [6:0] a);
        logic signed [9:0] vw;
        logic signed [9:0] mw;
        logic signed [9:0] sw;
        logic signed [9:0] rw;
        vw = {{2{v[7]}}, v};
        mw = {3'b000, m};
        sw = vw + $signed({3'b000, a});
        rw = vw;
        if (vw < mw)
        begin
            rw = (sw > mw) ? mw : sw;
        end
        return rw[7:0];
    endfunction

    // Step a speed down, stopping at the negative limit
    function automatic logic signed [7:0] step_down(input logic signed [7:0] v,
                                                     input logic [6:0] m,
                                                     input logic [6:0] a);
        logic signed [9:0] vw;
        logic signed [9:0] nw;
        logic signed [9:0] sw;
        logic signed [9:0] rw;
        vw = {{2{v[7]}}, v};
        nw = -$signed({3'b000, m});
        sw = vw - $signed({3'b000, a});
        rw = vw;
        if (vw > nw)
        begin
            rw = (sw < nw) ? nw : sw;
        end
        return rw[7:0];
    endfunction

    // Brake a speed toward zero in the direction of the gear
    function automatic logic signed [7:0] brake_one(input logic signed [7:0] v,
                                                     input logic [6:0] b,
                                                     input logic fwd);
        logic signed [9:0] vw;
        logic signed [9:0] bw;
        logic signed [9:0] rw;
        vw = {{2{v[7]}}, v};
        bw = {3'b000, b};
        rw = vw;
        if (fwd)
        begin
            if (vw > 10'sd0)
            begin
                rw = (vw > bw) ? vw - bw : 10'sd0;
            end
        end
        else
        begin
            if (vw < 10'sd0)
            begin
                rw = (vw < -bw) ? vw + bw : 10'sd0;
            end
        end
        return rw[7:0];
    endfunction

    // Act on a good packet
    always_comb
    begin
        right_level_next  = right_level_reg;
        left_level_next   = left_level_reg;
        gear_forward_next = gear_forward_reg;
        beam_next         = beam_reg;
        left_ind_next     = left_ind_reg;
        right_ind_next    = right_ind_reg;
        horn              = 1'b0;
        turn              = bpdc_pkg::TURN_NONE;
        if (cmd.good)
        begin
            unique case (cmd.number)
                bpdc_pkg::BTN_HORN:
                begin
                    horn = cmd.pressed;
                end
                bpdc_pkg::BTN_BEAM:
                begin
                    if (cmd.pressed)
                    begin
                        beam_next = !beam_reg;
                    end
                end
                bpdc_pkg::BTN_BRAKE:
                begin
                    if (cmd.pressed)
                    begin
                        right_level_next = brake_one(right_level_reg, cfg.brake_step,
                                                     gear_forward_reg);
                        left_level_next  = brake_one(left_level_reg, cfg.brake_step,
                                                     gear_forward_reg);
                    end
                end
                bpdc_pkg::BTN_UP:
                begin
                    if (cmd.pressed)
                    begin
                        if (!gear_forward_reg)
                        begin
                            gear_forward_next = 1'b1;
                            right_level_next  = 8'sd0;
                            left_level_next   = 8'sd0;
                        end
                        else
                        begin
                            right_level_next = step_up(right_level_reg, cfg.max_speed,
                                                       cfg.accel_step);
                            left_level_next  = step_up(left_level_reg, cfg.max_speed,
                                                       cfg.accel_step);
                        end
                    end
                end
                bpdc_pkg::BTN_DOWN:
                begin
                    if (cmd.pressed)
                    begin
                        if (gear_forward_reg)
                        begin
                            gear_forward_next = 1'b0;
                            right_level_next  = 8'sd0;
                            left_level_next   = 8'sd0;
                        end
                        else
                        begin
                            right_level_next = step_down(right_level_reg, cfg.max_speed,
                                                         cfg.accel_step);
                            left_level_next  = step_down(left_level_reg, cfg.max_speed,
                                                         cfg.accel_step);
                        end
                    end
                end
                bpdc_pkg::BTN_LEFT:
                begin
                    left_ind_next = cmd.pressed;
                    if (cmd.pressed)
                    begin
                        turn = bpdc_pkg::TURN_LEFT;
                    end
                end
                bpdc_pkg::BTN_RIGHT:
                begin
                    right_ind_next = cmd.pressed;
                    if (cmd.pressed)
                    begin
                        turn = bpdc_pkg::TURN_RIGHT;
                    end
                end
                default:
                begin
                    horn = 1'b0;
                end
            endcase
        end
    end

    // Present the status after this byte
    always_comb
    begin
        status.right_wheel = right_level_next;
        status.left_wheel  = left_level_next;
        status.forward     = gear_forward_next;
        status.beam        = beam_next;
        status.horn        = horn;
        status.left_sig    = left_ind_next;
        status.right_sig   = right_ind_next;
        status.turn        = turn;
    end

    // Hold the car state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_level_reg  <= 8'sd0;
            left_level_reg   <= 8'sd0;
            gear_forward_reg <= 1'b1;
            beam_reg         <= 1'b0;
            left_ind_reg     <= 1'b0;
            right_ind_reg    <= 1'b0;
        end
        else if (advance)
        begin
            right_level_reg  <= right_level_next;
            left_level_reg   <= left_level_next;
            gear_forward_reg <= gear_forward_next;
            beam_reg         <= beam_next;
            left_ind_reg     <= left_ind_next;
            right_ind_reg    <= right_ind_next;
        end
    end

    // Both wheels always receive the same commands
    a_wheels_match: assert property (@(posedge clk) disable iff (!rst_n)
        right_level_reg == left_level_reg)
        else $error("wheel speeds diverged");

    // A gear change clears both speeds
    a_gear_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (gear_forward_reg != $past(gear_forward_reg)) |->
            (right_level_reg == 8'sd0 && left_level_reg == 8'sd0))
        else $error("gear changed without clearing speeds");

    // Beam state moves only on a taken good packet
    a_beam_on_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (beam_reg != $past(beam_reg)) |-> ($past(advance) && $past(cmd.good)))
        else $error("high beam toggled without a good packet");

endmodule

FILE: hw/rtl/button_packet_drive_control.sv
// ----------------------------------------------------------------------------
// Button packet drive control (top level)
// Decodes control pad button packets from a serial byte stream and drives
// wheel speeds, gear, high beams, horn and indicators of a two-wheel car.
//
//   Channel  Handshake            Payload
//   -------  -------------------  ------------------------------------------
//   in       in_valid / in_stall  rx_byte
//   out      out_valid/ out_stall packet_valid .. turn_request (one per byte)
//   cfg      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// One byte per cycle sustained while out_stall is low; a taken byte passes
// through the input register and then the result register, from which
// its result is presented with out_valid on the out channel.
// Reset clears the parser to hunting, speeds to zero, gear to forward and
// loads max_speed 100, accel_step 10, brake_step 10; no clearing pass.
// in_stall rises only when a byte waits in the input register and the
// result register is full and stalled.
// ----------------------------------------------------------------------------
module button_packet_drive_control (
    input  logic              clk,
    input  logic              rst_n,
    // input bytes
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    // results
    output logic              out_valid,
    input  logic              out_stall,
    output logic              packet_valid,
    output logic              checksum_error,
    output logic signed [7:0] right_wheel_speed,
    output logic signed [7:0] left_wheel_speed,
    output logic              forward_gear,
    output logic              high_beam_on,
    output logic              horn_trigger,
    output logic              left_signal,
    output logic              right_signal,
    output logic [1:0]        turn_request,
    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_data
);

    logic              in_full_reg;
    logic              in_full_next;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic              in_accept;
    logic              advance;
    bpdc_pkg::cfg_t    cfg_reg;
    bpdc_pkg::cmd_t    cmd;
    bpdc_pkg::status_t status;
    logic              pv_reg;
    logic              ce_reg;
    bpdc_pkg::status_t status_reg;

    // Handshake and stage control
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_full_reg && out_free;
    assign in_stall  = in_full_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_accept)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming item
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_speed  <= bpdc_pkg::MAX_SPEED_RST;
            cfg_reg.accel_step <= bpdc_pkg::ACCEL_STEP_RST;
            cfg_reg.brake_step <= bpdc_pkg::BRAKE_STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bpdc_pkg::CFG_MAX_SPEED:  cfg_reg.max_speed  <= cfg_data;
                bpdc_pkg::CFG_ACCEL_STEP: cfg_reg.accel_step <= cfg_data;
                bpdc_pkg::CFG_BRAKE_STEP: cfg_reg.brake_step <= cfg_data;
                default:                  cfg_reg            <= cfg_reg;
            endcase
        end
    end

    bpdc_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_data (in_byte_reg),
        .cmd     (cmd)
    );

    bpdc_drive u_drive (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .status  (status)
    );

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pv_reg     <= cmd.good;
            ce_reg     <= cmd.bad;
            status_reg <= status;
        end
    end

    assign out_valid         = out_valid_reg;
    assign packet_valid      = pv_reg;
    assign checksum_error    = ce_reg;
    assign right_wheel_speed = status_reg.right_wheel;
    assign left_wheel_speed  = status_reg.left_wheel;
    assign forward_gear      = status_reg.forward;
    assign high_beam_on      = status_reg.beam;
    assign horn_trigger      = status_reg.horn;
    assign left_signal       = status_reg.left_sig;
    assign right_signal      = status_reg.right_sig;
    assign turn_request      = status_reg.turn;

    // The input stalls only when an item waits and the held result is stalled
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_full_reg && out_valid_reg && out_stall))
        else $error("input stalled while result register could take an item");

    // Horn and turn pulses only come with a good packet
    a_pulse_needs_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (horn_trigger || turn_request != bpdc_pkg::TURN_NONE))
            |-> packet_valid)
        else $error("horn or turn pulse without a good packet");

    // Turn request never carries the unused code
    a_turn_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (turn_request == bpdc_pkg::TURN_NONE ||
                           turn_request == bpdc_pkg::TURN_LEFT ||
                           turn_request == bpdc_pkg::TURN_RIGHT))
        else $error("turn request carries an unused code");

endmodule
